// ===== rtl/sha1bs_pkg.sv =====
`timescale 1ns / 1ps

package sha1bs_pkg;

  // Operation codes of an input item
  localparam logic OP_ABSORB = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  // Padding marker byte
  localparam logic [7:0] PAD_BYTE = 8'h80;

  localparam int ROUNDS     = 80;
  localparam int BLOCK_BITS = 512;
  localparam int WORDS      = 5;

  // Working variables of the compression
  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    logic [31:0] e;
  } work_t;

  typedef logic [31:0] word_t;

  localparam word_t H_INIT [WORDS] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  localparam word_t ROUND_K [4] = '{
    32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hCA62C1D6
  };

endpackage

// ===== rtl/sha1bs_sched.sv =====
`timescale 1ns / 1ps

// Message window: 64 bytes shift in during fill, then the window slides one
// word per round and appends the expanded schedule word.
module sha1bs_sched (
  input  logic                 clk,
  input  logic                 byte_en,
  input  logic [7:0]           byte_val,
  input  logic                 word_en,
  output sha1bs_pkg::word_t    w_cur
);
  import sha1bs_pkg::*;

  logic [BLOCK_BITS-1:0] msg;
  word_t                 w_tmp;
  word_t                 w_new;

  // Taps: w[t-16], w[t-14], w[t-8], w[t-3] relative to the word being appended
  assign w_cur = msg[511:480];
  assign w_tmp = msg[511:480] ^ msg[447:416] ^ msg[255:224] ^ msg[95:64];
  assign w_new = {w_tmp[30:0], w_tmp[31]};

  always_ff @(posedge clk) begin
    if (byte_en) begin
      msg <= {msg[BLOCK_BITS-9:0], byte_val};
    end else if (word_en) begin
      msg <= {msg[BLOCK_BITS-33:0], w_new};
    end
  end

endmodule

// ===== rtl/sha1bs_round.sv =====
`timescale 1ns / 1ps

// One SHA-1 round, reused for all 80 rounds of a block.
module sha1bs_round (
  input  sha1bs_pkg::work_t  cur,
  input  sha1bs_pkg::word_t  w,
  input  logic [6:0]         rnd,
  output sha1bs_pkg::work_t  nxt
);
  import sha1bs_pkg::*;

  word_t      f;
  logic [1:0] ksel;
  word_t      t;

  // Round function and constant by round group
  always_comb begin
    if (rnd < 7'd20) begin
      f    = (cur.b & cur.c) | (~cur.b & cur.d);
      ksel = 2'd0;
    end else if (rnd < 7'd40) begin
      f    = cur.b ^ cur.c ^ cur.d;
      ksel = 2'd1;
    end else if (rnd < 7'd60) begin
      f    = (cur.b & cur.c) | (cur.b & cur.d) | (cur.c & cur.d);
      ksel = 2'd2;
    end else begin
      f    = cur.b ^ cur.c ^ cur.d;
      ksel = 2'd3;
    end
  end

  assign t = {cur.a[26:0], cur.a[31:27]} + f + cur.e + ROUND_K[ksel] + w;

  always_comb begin
    nxt.a = t;
    nxt.b = cur.a;
    nxt.c = {cur.b[1:0], cur.b[31:2]};
    nxt.d = cur.c;
    nxt.e = cur.d;
  end

endmodule

// ===== rtl/sha1_byte_stream_hasher.sv =====
`timescale 1ns / 1ps

// SHA-1 hasher over a byte stream.
// Input channel (in_valid/in_ready): operation selects absorb (one message
// byte in data_byte) or finish (data_byte ignored). in_ready is high only
// while the block is idle.
// An absorb is taken in the idle state; every 64th byte adds a compression
// (80 rounds through one shared round unit, then the chaining add).
// A finish pads one byte per cycle (64 - n bytes, or 128 - n when the
// marker falls past byte 55, with n bytes pending), runs one or two
// compressions, then presents five digest items on the output channel
// (out_valid/out_ready), word_index 0 to 4, last_word on the fifth.
// Each digest item stays until taken; a stalled receiver holds the block,
// and no input is taken until the fifth item is accepted.
// After the fifth item the chaining value and byte count return to their
// initial values, ready for a new message.
// Reset (rst, synchronous) brings the same initial state at once.
module sha1_byte_stream_hasher (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        operation,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);
  import sha1bs_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PAD   = 3'd1;
  localparam logic [2:0] S_ROUND = 3'd2;
  localparam logic [2:0] S_ADD   = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0]  state;
  logic [6:0]  rnd;
  word_t       h [WORDS];
  work_t       wk;
  work_t       wk_next;
  logic [5:0]  fill;
  logic [54:0] blk_cnt;
  logic [63:0] len_sr;
  logic        pad_first;
  logic        len_here;
  logic        final_blk;
  logic        pad_mode;
  logic [2:0]  out_idx;

  logic        in_acc;
  logic [7:0]  pad_byte;
  logic        byte_en;
  logic [7:0]  byte_val;
  word_t       w_cur;
  work_t       h_work;

  assign in_ready = (state == S_IDLE);
  assign in_acc   = in_valid && in_ready;

  // Padding byte: marker, then zeros, then the big-endian length
  always_comb begin
    if (pad_first) begin
      pad_byte = PAD_BYTE;
    end else if (fill >= 6'd56 && len_here) begin
      pad_byte = len_sr[63:56];
    end else begin
      pad_byte = 8'h00;
    end
  end

  assign byte_en  = (in_acc && operation == OP_ABSORB) || (state == S_PAD);
  assign byte_val = (state == S_PAD) ? pad_byte : data_byte;

  assign h_work = '{a: h[0], b: h[1], c: h[2], d: h[3], e: h[4]};

  sha1bs_sched u_sched (
    .clk      (clk),
    .byte_en  (byte_en),
    .byte_val (byte_val),
    .word_en  (state == S_ROUND),
    .w_cur    (w_cur)
  );

  sha1bs_round u_round (
    .cur (wk),
    .w   (w_cur),
    .rnd (rnd),
    .nxt (wk_next)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rnd       <= '0;
      fill      <= '0;
      blk_cnt   <= '0;
      pad_first <= 1'b0;
      len_here  <= 1'b0;
      final_blk <= 1'b0;
      pad_mode  <= 1'b0;
      out_idx   <= '0;
      for (int i = 0; i < WORDS; i++) begin
        h[i] <= H_INIT[i];
      end
    end else begin
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            if (operation == OP_ABSORB) begin
              fill <= fill + 6'd1;
              if (fill == 6'd63) begin
                blk_cnt  <= blk_cnt + 55'd1;
                pad_mode <= 1'b0;
                rnd      <= '0;
                wk       <= h_work;
                state    <= S_ROUND;
              end
            end else begin
              len_sr    <= {blk_cnt, fill, 3'b000};
              pad_first <= 1'b1;
              len_here  <= 1'b0;
              pad_mode  <= 1'b1;
              state     <= S_PAD;
            end
          end
        end
        S_PAD: begin
          fill      <= fill + 6'd1;
          pad_first <= 1'b0;
          if (pad_first && fill < 6'd56) begin
            len_here <= 1'b1;
          end
          if (!pad_first && fill >= 6'd56 && len_here) begin
            len_sr <= {len_sr[55:0], 8'h00};
          end
          if (fill == 6'd63) begin
            final_blk <= len_here;
            rnd       <= '0;
            wk        <= h_work;
            state     <= S_ROUND;
          end
        end
        S_ROUND: begin
          wk  <= wk_next;
          rnd <= rnd + 7'd1;
          if (rnd == 7'(ROUNDS - 1)) begin
            state <= S_ADD;
          end
        end
        S_ADD: begin
          h[0] <= h[0] + wk.a;
          h[1] <= h[1] + wk.b;
          h[2] <= h[2] + wk.c;
          h[3] <= h[3] + wk.d;
          h[4] <= h[4] + wk.e;
          if (!pad_mode) begin
            state <= S_IDLE;
          end else if (final_blk) begin
            out_idx <= '0;
            state   <= S_OUT;
          end else begin
            // Marker went past byte 55: length goes in a second block
            len_here <= 1'b1;
            state    <= S_PAD;
          end
        end
        S_OUT: begin
          if (out_ready) begin
            out_idx <= out_idx + 3'd1;
            if (out_idx == 3'(WORDS - 1)) begin
              for (int i = 0; i < WORDS; i++) begin
                h[i] <= H_INIT[i];
              end
              fill     <= '0;
              blk_cnt  <= '0;
              pad_mode <= 1'b0;
              state    <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Digest items
  assign out_valid   = (state == S_OUT);
  assign digest_word = h[out_idx];
  assign word_index  = out_idx;
  assign last_word   = (out_idx == 3'(WORDS - 1));

endmodule

// ===== rtl/sha1bs_checker.sv =====
`timescale 1ns / 1ps

module sha1bs_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] digest_word,
  input logic [2:0]  word_index,
  input logic        last_word
);

  // A stalled digest item holds its contents
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(digest_word)
      && $stable(word_index))
    else $error("digest item changed while stalled");

  // No input is taken while the digest is being delivered
  a_no_in_during_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input ready during digest output");

  // last_word marks exactly the fifth word
  a_last_idx: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last_word == (word_index == 3'd4)))
    else $error("last_word does not match word_index");

  // Words advance in order, and the burst ends after the last one
  a_idx_step: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_word |=> out_valid
      && word_index == $past(word_index) + 3'd1)
    else $error("digest word index out of order");

  a_burst_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && last_word |=> !out_valid && in_ready)
    else $error("digest output continued past last word");

endmodule

bind sha1_byte_stream_hasher sha1bs_checker u_sha1bs_checker (.*);
